// ----- hdl/max_tracking_stack_macros.svh -----
// ----------------------------------------------------------------------------
// Max tracking stack assertion macros
// Shared forms for the concurrent checks of the stack.
// ----------------------------------------------------------------------------
`ifndef MAX_TRACKING_STACK_MACROS_SVH
`define MAX_TRACKING_STACK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// Max tracking stack package
// Transaction types, codes and the stack entry shared by the stack modules.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int DEPTH_WIDTH = 8;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} mts_op_t;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} mts_status_t;

	typedef struct packed {
		mts_op_t                       operation;
		logic signed [DATA_WIDTH-1:0]  value;
	} mts_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  popped_value;
		logic signed [DATA_WIDTH-1:0]  current_max;
		logic                          max_valid;
		logic [DEPTH_WIDTH-1:0]        depth;
		mts_status_t                   status;
	} mts_result_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  value;
		logic signed [DATA_WIDTH-1:0]  max;
	} mts_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} mts_shift_t;

endpackage

// ----- hdl/mts_cell.sv -----
// ----------------------------------------------------------------------------
// Max tracking stack cell
// One stack slot holding a value and the running maximum at its depth.
// ----------------------------------------------------------------------------
module mts_cell
	import mts_pkg::*;
(
	input  logic       clk,
	input  mts_shift_t shift,
	input  mts_entry_t above,
	input  mts_entry_t below,
	output mts_entry_t entry
);

	mts_entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= above;
		end else if (shift.pop) begin
			entry_q <= below;
		end
	end

	assign entry = entry_q;

endmodule

// ----- hdl/max_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// Max tracking stack
// Bounded LIFO of signed values that reports the maximum of its contents.
// ----------------------------------------------------------------------------
// The stack is a row of STACK_DEPTH cells; cell 0 is the top. A push shifts
// every cell one place down and a pop one place up, and a new transaction is
// accepted every cycle unless the input stalls. The result appears in an
// output register in the cycle after acceptance, and the input stalls only while
// that register holds a result that is itself stalled.
module max_tracking_stack
	import mts_pkg::*;
#(
	parameter int STACK_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  mts_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output mts_result_t result
);

	`include "max_tracking_stack_macros.svh"

	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic             result_valid_q;
	mts_result_t      result_q;
	mts_result_t      result_next;
	logic             accept;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	mts_shift_t       shift;
	mts_entry_t       new_entry;
	mts_entry_t       cell_out [STACK_DEPTH];
	logic [CW+DEPTH_WIDTH-1:0] depth_wide;

	assign item_stall = result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign full       = (count_q == CW'(STACK_DEPTH));
	assign empty      = (count_q == '0);
	assign do_push    = accept && (item.operation == OP_PUSH) && !full;
	assign do_pop     = accept && (item.operation == OP_POP) && !empty;

	assign shift.push = do_push;
	assign shift.pop  = do_pop;

	always_comb begin
		new_entry.value = item.value;
		if (!empty && !(item.value > cell_out[0].max)) begin
			new_entry.max = cell_out[0].max;
		end else begin
			new_entry.max = item.value;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			mts_entry_t above;
			mts_entry_t below;
			if (gi == 0) begin : g_top
				assign above = new_entry;
			end else begin : g_mid
				assign above = cell_out[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_bottom
				assign below = cell_out[gi];
			end else begin : g_upper
				assign below = cell_out[gi+1];
			end
			mts_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.above (above),
				.below (below),
				.entry (cell_out[gi])
			);
		end
	endgenerate

	always_comb begin
		count_next               = count_q;
		result_next.popped_value = '0;
		result_next.status       = STATUS_DONE;
		result_next.current_max  = '0;
		if (item.operation == OP_PUSH) begin
			if (full) begin
				result_next.status = STATUS_FULL;
				if (!empty) begin
					result_next.current_max = cell_out[0].max;
				end
			end else begin
				count_next              = count_q + CW'(1);
				result_next.current_max = new_entry.max;
			end
		end else begin
			if (empty) begin
				result_next.status = STATUS_EMPTY;
			end else begin
				count_next               = count_q - CW'(1);
				result_next.popped_value = cell_out[0].value;
				if (count_q != CW'(1)) begin
					result_next.current_max = cell_out[1].max;
				end
			end
		end
		depth_wide            = {{DEPTH_WIDTH{1'b0}}, count_next};
		result_next.depth     = depth_wide[DEPTH_WIDTH-1:0];
		result_next.max_valid = (count_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q        <= count_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MTS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH),
		"Entry count exceeds the stack depth.")
	`MTS_ASSERT_NEXT(a_push_grows, do_push, count_q == $past(count_q) + CW'(1),
		"Accepted push did not grow the stack by one.")
	`MTS_ASSERT_NEXT(a_pop_value, do_pop,
		result_valid && result.popped_value == $past(cell_out[0].value),
		"Popped value does not match the former top entry.")
	`MTS_ASSERT_NEXT(a_max_valid, accept, result.max_valid == (count_q != '0),
		"Maximum valid flag disagrees with the entry count.")

endmodule

// ----- bench/tb_max_tracking_stack.sv -----
// ----------------------------------------------------------------------------
// Max tracking stack testbench
// Drives push and pop transactions with random gaps and output stalls, and
// checks results against the directed table or a behavioral running-max stack.
// ----------------------------------------------------------------------------
module tb_max_tracking_stack;
	import mts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH  = 128;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_GAP      = 13;
	localparam int LONG_HOLD    = 400;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} traffic_mode_t;

	typedef struct {
		mts_op_t                      op;
		logic signed [DATA_WIDTH-1:0] value;
		bit                           typed;
		mts_result_t                  want;
	} stimulus_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	mts_item_t   item;
	logic        result_valid;
	logic        result_stall;
	mts_result_t result;

	logic signed [DATA_WIDTH-1:0] held_values[$];
	logic signed [DATA_WIDTH-1:0] running_max[$];
	mts_result_t                  pending_results[$];
	int                           mismatches;
	int                           results_seen;

	localparam logic signed [DATA_WIDTH-1:0] MAX_POS = 32'h7fffffff;
	localparam logic signed [DATA_WIDTH-1:0] MIN_NEG = 32'h80000000;

	stimulus_row_t directed_rows[] = '{
		'{OP_POP,  32'h0,        1'b1, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_EMPTY}},
		'{OP_PUSH, MAX_POS,      1'b1, '{32'h0, MAX_POS, 1'b1, 8'd1, STATUS_DONE}},
		'{OP_PUSH, MIN_NEG,      1'b1, '{32'h0, MAX_POS, 1'b1, 8'd2, STATUS_DONE}},
		'{OP_POP,  32'h1234,     1'b1, '{MIN_NEG, MAX_POS, 1'b1, 8'd1, STATUS_DONE}},
		'{OP_POP,  32'hffffffff, 1'b1, '{MAX_POS, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b1, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_EMPTY}},
		'{OP_PUSH, MIN_NEG,      1'b1, '{32'h0, MIN_NEG, 1'b1, 8'd1, STATUS_DONE}},
		'{OP_PUSH, 32'd5,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_PUSH, 32'd5,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_PUSH, -32'sd3,      1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_PUSH, 32'd5,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_PUSH, 32'd9,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b1, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_EMPTY}},
		'{OP_PUSH, 32'hffffffff, 1'b1, '{32'h0, 32'hffffffff, 1'b1, 8'd1, STATUS_DONE}},
		'{OP_PUSH, 32'h55555555, 1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_PUSH, 32'haaaaaaaa, 1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b0, '{32'h0, 32'h0, 1'b0, 8'd0, STATUS_DONE}},
		'{OP_POP,  32'h0,        1'b1, '{32'hffffffff, 32'h0, 1'b0, 8'd0, STATUS_DONE}}
	};

	max_tracking_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Applies one transaction to the behavioral stack and returns its result.
	function automatic mts_result_t stack_step(input mts_item_t txn);
		mts_result_t                  res;
		logic signed [DATA_WIDTH-1:0] top_max;
		res = '0;
		res.status = STATUS_DONE;
		if (txn.operation == OP_PUSH) begin
			if (held_values.size() >= STACK_DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				top_max = txn.value;
				if (running_max.size() > 0 && !(txn.value > running_max[$])) begin
					top_max = running_max[$];
				end
				held_values.push_back(txn.value);
				running_max.push_back(top_max);
			end
		end else if (held_values.size() == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			res.popped_value = held_values.pop_back();
			void'(running_max.pop_back());
		end
		if (held_values.size() > 0) begin
			res.current_max = running_max[$];
			res.max_valid = 1'b1;
		end
		res.depth = DEPTH_WIDTH'(held_values.size());
		return res;
	endfunction

	task automatic send_txn(input mts_item_t txn, input int gap, input bit typed,
			input mts_result_t want);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= txn;
		do @(posedge clk); while (item_stall);
		if (typed) begin
			void'(stack_step(txn));
			pending_results.push_back(want);
		end else begin
			pending_results.push_back(stack_step(txn));
		end
	endtask

	task automatic compare_field(input string field, input logic [DATA_WIDTH-1:0] want,
			input logic [DATA_WIDTH-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s expected %h got %h", $realtime, field, want, got);
			end
		end
	endtask

	always @(posedge clk) begin
		mts_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected result %h", $realtime, result);
				end
			end else begin
				want = pending_results.pop_front();
				compare_field("popped_value", want.popped_value, result.popped_value);
				compare_field("current_max", want.current_max, result.current_max);
				compare_field("max_valid", DATA_WIDTH'(want.max_valid),
					DATA_WIDTH'(result.max_valid));
				compare_field("depth", DATA_WIDTH'(want.depth), DATA_WIDTH'(result.depth));
				compare_field("status", DATA_WIDTH'(want.status),
					DATA_WIDTH'(result.status));
			end
		end
	end

	// Output side: random stall per result, quiet stretches, and one long hold.
	initial begin
		int  hold;
		int  handled;
		bit  held_off;
		result_stall = 1'b0;
		handled = 0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && results_seen >= 300) begin
				hold = LONG_HOLD;
				held_off = 1'b1;
			end else if ((handled / 50) % 4 == 2) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, MAX_GAP);
			end
			@(negedge clk);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			handled++;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[max_tracking_stack] ERROR");
		$finish;
	end

	initial begin
		mts_item_t     txn;
		traffic_mode_t mode;
		int            seg_left;
		int            push_pct;
		int            gap;
		mismatches = 0;
		results_seen = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			txn.operation = directed_rows[i].op;
			txn.value = directed_rows[i].value;
			send_txn(txn, $urandom_range(0, MAX_GAP), directed_rows[i].typed,
				directed_rows[i].want);
		end

		mode = MODE_FILL;
		seg_left = 200;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				mode = (n < 400) ? MODE_DRAIN : traffic_mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			case (mode)
				MODE_FILL:  push_pct = 94;
				MODE_DRAIN: push_pct = 6;
				default:    push_pct = 50;
			endcase
			txn.operation = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
			case ($urandom_range(0, 5))
				0:       txn.value = $signed($urandom_range(0, 8)) - 4;
				1:       txn.value = $urandom_range(0, 1) ? MAX_POS : MIN_NEG;
				default: txn.value = $urandom;
			endcase
			gap = ((n / 60) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
			send_txn(txn, gap, 1'b0, '0);
		end
		@(negedge clk);
		item_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[max_tracking_stack] OK");
		end else begin
			$display("[max_tracking_stack] ERROR");
		end
		$finish;
	end

endmodule
